### hw/rtl/stc_pkg.sv
`default_nettype none

package stc_pkg;

    // Default batch depth and element width.
    localparam int MAX_N_DEF      = 64;
    localparam int VALUE_BITS_DEF = 32;

    // Width of one smaller-element count.
    localparam int COUNT_BITS = 6;

    // Sequencer states: collecting a batch, or streaming its counts out.
    typedef enum logic {
        ST_FILL,
        ST_DUMP
    } t_state;

    // Control that the sequencer sends to every cell of the row.
    typedef struct packed {
        logic compare;
        logic shift;
    } t_cell_ctrl;

endpackage

`default_nettype wire

### hw/rtl/smaller_to_right_counter.sv
// Counts, for each element of a batch, how many later elements of the same batch are
// strictly smaller. Elements enter one per cycle while i_in_valid is high and o_in_stall
// is low; the beat carrying i_last_item closes the batch. Each arrival is compared against
// all stored elements at once by a row of MAX_N cells, so the input sustains one beat per
// cycle throughout a batch. After the last beat the counts leave in arrival order, one
// beat per cycle while i_out_stall is low, as the row shifts toward cell zero, with
// o_final_result on the final one; the input is stalled for that readout. Elements beyond
// MAX_N are dropped and every result of that batch carries o_overflow.
`default_nettype none

module smaller_to_right_counter #(
    parameter int MAX_N      = stc_pkg::MAX_N_DEF,
    parameter int VALUE_BITS = stc_pkg::VALUE_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic signed [VALUE_BITS-1:0]    i_value,
    input  wire logic                            i_last_item,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic      [stc_pkg::COUNT_BITS-1:0]  o_smaller_count,
    output logic                                 o_final_result,
    output logic                                 o_overflow
);

    localparam int FILL_W = $clog2(MAX_N + 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(MAX_N);
    localparam logic [FILL_W-1:0] FILL_ONE = FILL_W'(1);

    stc_pkg::t_state     r_state;
    stc_pkg::t_state     n_state;
    logic [FILL_W-1:0]   r_fill;
    logic [FILL_W-1:0]   n_fill;
    logic                r_dropped;
    logic                n_dropped;
    stc_pkg::t_cell_ctrl w_ctrl;
    logic                w_in_acc;
    logic                w_full;
    logic                w_out_free;
    logic                w_last_out;

    logic                            r_out_valid;
    logic [stc_pkg::COUNT_BITS-1:0]  r_out_count;
    logic                            r_out_final;
    logic                            r_out_ovf;

    logic [stc_pkg::COUNT_BITS-1:0]  w_count [MAX_N];

    assign o_in_stall = (r_state == stc_pkg::ST_DUMP);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_full     = (r_fill == FILL_MAX);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_last_out = (r_fill == FILL_ONE);

    // Sequencer: next state, cell control and fill bookkeeping.
    always_comb begin
        n_state        = r_state;
        n_fill         = r_fill;
        n_dropped      = r_dropped;
        w_ctrl.compare = 1'b0;
        w_ctrl.shift   = 1'b0;
        unique case (r_state)
            stc_pkg::ST_FILL: begin
                if (w_in_acc) begin
                    if (w_full) begin
                        n_dropped = 1'b1;
                    end else begin
                        w_ctrl.compare = 1'b1;
                        n_fill         = r_fill + FILL_ONE;
                    end
                    if (i_last_item) begin
                        n_state = stc_pkg::ST_DUMP;
                    end
                end
            end
            stc_pkg::ST_DUMP: begin
                if (w_out_free) begin
                    w_ctrl.shift = 1'b1;
                    n_fill       = r_fill - FILL_ONE;
                    if (w_last_out) begin
                        n_dropped = 1'b0;
                        n_state   = stc_pkg::ST_FILL;
                    end
                end
            end
            default: begin
                n_state = stc_pkg::ST_FILL;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= stc_pkg::ST_FILL;
            r_fill    <= '0;
            r_dropped <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_dropped <= n_dropped;
        end
    end

    // Row of compare cells; counts move toward cell zero during readout.
    for (genvar g = 0; g < MAX_N; g++) begin : g_cell
        logic [stc_pkg::COUNT_BITS-1:0] w_next;
        if (g == MAX_N - 1) begin : g_end
            assign w_next = '0;
        end else begin : g_mid
            assign w_next = w_count[g+1];
        end

        stc_cell #(
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_key        (i_value),
            .i_wr_sel     (r_fill == FILL_W'(g)),
            .i_active     (r_fill > FILL_W'(g)),
            .i_next_count (w_next),
            .o_count      (w_count[g])
        );
    end

    // Output register: holds a beat while the consumer stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctrl.shift) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.shift) begin
            r_out_count <= w_count[0];
            r_out_final <= w_last_out;
            r_out_ovf   <= r_dropped;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_smaller_count = r_out_count;
    assign o_final_result  = r_out_final;
    assign o_overflow      = r_out_ovf;

endmodule

`default_nettype wire

### hw/rtl/stc_cell.sv
`default_nettype none

module stc_cell #(
    parameter int VALUE_BITS = stc_pkg::VALUE_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire stc_pkg::t_cell_ctrl             i_ctrl,
    input  wire logic signed [VALUE_BITS-1:0]    i_key,
    input  wire logic                            i_wr_sel,
    input  wire logic                            i_active,
    input  wire logic [stc_pkg::COUNT_BITS-1:0]  i_next_count,
    output logic      [stc_pkg::COUNT_BITS-1:0]  o_count
);

    logic signed [VALUE_BITS-1:0]          r_value;
    logic        [stc_pkg::COUNT_BITS-1:0] r_count;
    logic        [stc_pkg::COUNT_BITS-1:0] n_count;
    logic                                  w_greater;

    // A stored element counts the arrival when it is strictly greater.
    assign w_greater = i_active && (r_value > i_key);

    // Count update: store a fresh element, bump on a smaller arrival,
    // or take the neighbor's count while the batch is read out.
    always_comb begin
        n_count = r_count;
        if (i_ctrl.compare) begin
            if (i_wr_sel) begin
                n_count = '0;
            end else if (w_greater) begin
                n_count = r_count + {{(stc_pkg::COUNT_BITS-1){1'b0}}, 1'b1};
            end
        end else if (i_ctrl.shift) begin
            n_count = i_next_count;
        end
    end

    // The value is captured only when this cell is the next free slot.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.compare && i_wr_sel) begin
            r_value <= i_key;
        end
        r_count <= n_count;
    end

    assign o_count = r_count;

endmodule

`default_nettype wire

### hw/rtl/stc_checker.sv
`default_nettype none

module stc_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_in_valid,
    input wire logic                            o_in_stall,
    input wire logic                            i_last_item,
    input wire logic                            o_out_valid,
    input wire logic                            i_out_stall,
    input wire logic [stc_pkg::COUNT_BITS-1:0]  o_smaller_count,
    input wire logic                            o_final_result,
    input wire logic                            o_overflow
);

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_smaller_count)
            && $stable(o_final_result) && $stable(o_overflow))
        else $error("result beat changed while stalled");

    // Closing a batch stops the input for readout.
    a_last_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_last_item |=> o_in_stall)
        else $error("input not stalled after the last beat of a batch");

    // A non-final count on the output means readout is still running.
    a_mid_readout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_final_result |-> o_in_stall)
        else $error("input open while a batch is only partly read out");

    // Input reopens only as the final count of the batch appears.
    a_reopen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_in_stall) |-> o_out_valid && o_final_result)
        else $error("input reopened without the final count");

endmodule

bind smaller_to_right_counter stc_checker u_stc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .i_last_item     (i_last_item),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_smaller_count (o_smaller_count),
    .o_final_result  (o_final_result),
    .o_overflow      (o_overflow)
);

`default_nettype wire

### test/smaller_to_right_counter_check.sv
`timescale 1ns / 1ps

module smaller_to_right_counter_check #(
    parameter int MAX_N      = stc_pkg::MAX_N_DEF,
    parameter int VALUE_BITS = stc_pkg::VALUE_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    input  wire logic                           i_in_stall,
    input  wire logic signed [VALUE_BITS-1:0]   i_value,
    input  wire logic                           i_last_item,
    input  wire logic                           i_out_valid,
    input  wire logic                           i_out_stall,
    input  wire logic [stc_pkg::COUNT_BITS-1:0] i_smaller_count,
    input  wire logic                           i_final_result,
    input  wire logic                           i_overflow,
    output int                                  o_fail_count,
    output int                                  o_pending,
    output int                                  o_checked
);

    // One expected count beat.
    typedef struct {
        logic [stc_pkg::COUNT_BITS-1:0] count;
        logic                           last_flag;
        logic                           ovf;
    } t_count_beat;

    // Private copy of the batch being collected.
    logic signed [VALUE_BITS-1:0]   batch_values [MAX_N];
    logic [stc_pkg::COUNT_BITS-1:0] batch_counts [MAX_N];
    int                             batch_fill    = 0;
    logic                           batch_dropped = 1'b0;

    t_count_beat awaited_counts [$];
    int          fails   = 0;
    int          checked = 0;

    // Compares the arriving element against the stored ones and, when it closes
    // the batch, queues one count per stored element in arrival order.
    task automatic absorb_element(input logic signed [VALUE_BITS-1:0] v, input logic last);
        int          k;
        t_count_beat beat;
        if (batch_fill < MAX_N) begin
            for (k = 0; k < batch_fill; k++) begin
                if (batch_values[k] > v) begin
                    batch_counts[k] = batch_counts[k] + 1'b1;
                end
            end
            batch_values[batch_fill] = v;
            batch_counts[batch_fill] = '0;
            batch_fill++;
        end else begin
            batch_dropped = 1'b1;
        end
        if (last) begin
            for (k = 0; k < batch_fill; k++) begin
                beat.count     = batch_counts[k];
                beat.last_flag = (k == batch_fill - 1);
                beat.ovf       = batch_dropped;
                awaited_counts.push_back(beat);
            end
            batch_fill    = 0;
            batch_dropped = 1'b0;
        end
    endtask

    function automatic int field_mismatch(input string what, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            return 1;
        end
        return 0;
    endfunction

    // Check output beats against the oldest expectation, then absorb input beats.
    always @(posedge i_clk) begin
        t_count_beat want;
        if (i_rst_n) begin
            if (i_out_valid && !i_out_stall) begin
                if (awaited_counts.size() == 0) begin
                    $display("%0t: unexpected count beat, expected none, actual count %0d",
                             $time, i_smaller_count);
                    fails++;
                end else begin
                    want = awaited_counts.pop_front();
                    fails += field_mismatch("smaller_count", want.count, i_smaller_count);
                    fails += field_mismatch("final_result", want.last_flag, i_final_result);
                    fails += field_mismatch("overflow", want.ovf, i_overflow);
                    checked++;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                absorb_element(i_value, i_last_item);
            end
        end
        o_fail_count <= fails;
        o_pending    <= awaited_counts.size();
        o_checked    <= checked;
    end

endmodule

### test/smaller_to_right_counter_test.sv
`timescale 1ns / 1ps

module smaller_to_right_counter_test;

    localparam int VB          = stc_pkg::VALUE_BITS_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_BEATS = 100;

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_in_valid  = 1'b0;
    logic signed [VB-1:0]           i_value     = '0;
    logic                           i_last_item = 1'b0;
    logic                           i_out_stall = 1'b0;
    logic                           o_in_stall;
    logic                           o_out_valid;
    logic [stc_pkg::COUNT_BITS-1:0] o_smaller_count;
    logic                           o_final_result;
    logic                           o_overflow;

    int fail_count;
    int pending;
    int checked;

    int   send_pct    = 0;
    int   recv_pct    = 0;
    logic hold_armed  = 1'b0;
    logic hold_done   = 1'b0;
    int   hold_left   = 0;
    int   cycle_count = 0;
    int   beats_sent  = 0;
    int   batches     = 0;

    always #2 i_clk = ~i_clk;

    smaller_to_right_counter dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_value         (i_value),
        .i_last_item     (i_last_item),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_smaller_count (o_smaller_count),
        .o_final_result  (o_final_result),
        .o_overflow      (o_overflow)
    );

    smaller_to_right_counter_check count_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_value         (i_value),
        .i_last_item     (i_last_item),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_smaller_count (o_smaller_count),
        .i_final_result  (o_final_result),
        .i_overflow      (o_overflow),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked)
    );

    // Receiver: random stall, plus one long hold-off once it is armed.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (hold_armed && !hold_done) begin
            hold_left   <= HOLD_CYCLES;
            hold_done   <= 1'b1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_pct);
        end
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("smaller_to_right_counter_test: errors");
            $finish;
        end
    end

    task automatic set_idling(input int send_idle, input int recv_idle);
        send_pct = send_idle;
        recv_pct <= recv_idle;
    endtask

    // Offer one element beat, with random idle cycles ahead of it, and wait for acceptance.
    task automatic send_beat(input logic signed [VB-1:0] v, input logic last);
        while ($urandom_range(0, 99) < send_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_value     <= v;
        i_last_item <= last;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        beats_sent++;
    endtask

    // Mix of full-range values, a narrow band that makes ties likely, and extremes.
    function automatic logic signed [VB-1:0] pick_value();
        case ($urandom_range(0, 3))
            1: return $signed($urandom_range(0, 7)) - 4;
            2: begin
                case ($urandom_range(0, 3))
                    0: return {1'b1, {(VB-1){1'b0}}};
                    1: return {1'b0, {(VB-1){1'b1}}};
                    2: return '0;
                    default: return '1;
                endcase
            end
            default: return $urandom();
        endcase
    endfunction

    task automatic send_batch(input int n);
        int k;
        for (k = 0; k < n; k++) begin
            send_beat(pick_value(), k == n - 1);
        end
        batches++;
    endtask

    // One idling phase: a large batch first, then short batches up to the budget.
    task automatic run_phase(input int big_size);
        int start_beats;
        start_beats = beats_sent;
        send_batch(big_size);
        while (beats_sent - start_beats < PHASE_BEATS) begin
            send_batch($urandom_range(1, 12));
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_idling(20, 84);

        // A batch of one element.
        send_beat(32'sd0, 1'b1);
        batches++;
        // Extremes, ties and alternating bit patterns.
        send_beat(32'sh7fffffff, 1'b0);
        send_beat(32'sh80000000, 1'b0);
        send_beat(-32'sd1, 1'b0);
        send_beat(32'sd0, 1'b0);
        send_beat(32'sh55555555, 1'b0);
        send_beat(32'shaaaaaaaa, 1'b0);
        send_beat(32'sd5, 1'b0);
        send_beat(32'sd5, 1'b0);
        send_beat(-32'sd1, 1'b1);
        batches++;
        // Repeated extremes only.
        send_beat(32'sh80000000, 1'b0);
        send_beat(32'sh80000000, 1'b0);
        send_beat(32'sh7fffffff, 1'b0);
        send_beat(32'sh7fffffff, 1'b1);
        batches++;
        // Strictly falling values give the largest counts.
        send_beat(32'sd6, 1'b0);
        send_beat(32'sd5, 1'b0);
        send_beat(32'sd4, 1'b0);
        send_beat(32'sd3, 1'b0);
        send_beat(32'sd2, 1'b0);
        send_beat(32'sd1, 1'b1);
        batches++;

        // Overflow batches drop their tail, the closing beat included.
        run_phase(stc_pkg::MAX_N_DEF + 1);
        set_idling(84, 20);
        run_phase(stc_pkg::MAX_N_DEF + 6);
        // A full batch behind a long output hold backs up the input.
        set_idling(0, 0);
        hold_armed <= 1'b1;
        run_phase(stc_pkg::MAX_N_DEF);

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (stc_pkg::MAX_N_DEF + 8) @(posedge i_clk);

        $display("Covered %0d element beats in %0d batches, %0d counts checked,",
                 beats_sent, batches, checked);
        $display("including ties, extremes, overflowed batches and a long output hold.");
        if (fail_count == 0) begin
            $display("smaller_to_right_counter_test: clean");
        end else begin
            $display("smaller_to_right_counter_test: errors");
        end
        $finish;
    end

endmodule

### smaller_to_right_counter.f
hw/rtl/stc_pkg.sv
hw/rtl/stc_cell.sv
hw/rtl/smaller_to_right_counter.sv
hw/rtl/stc_checker.sv
test/smaller_to_right_counter_check.sv
test/smaller_to_right_counter_test.sv
